[rtl/gcld_pkg.sv]
// ----------------------------------------------------------------------------
// gcld_pkg
// Types, constants and tables for the Gregorian to lunar date converter.
// ----------------------------------------------------------------------------
package gcld_pkg;

   localparam int unsigned FIRST_YEAR = 1901;
   localparam int unsigned YEAR_COUNT = 199;
   localparam int unsigned IDX_W      = 8;
   localparam int unsigned WALK_STAGES = 7;

   localparam logic [11:0] YEAR_LO = 12'(FIRST_YEAR);
   localparam logic [11:0] YEAR_HI = 12'(FIRST_YEAR + YEAR_COUNT - 1);

   typedef struct packed {
      logic [11:0] greg_year;
      logic [3:0]  greg_month;
      logic [4:0]  greg_day;
   } req_type;

   typedef struct packed {
      logic [3:0] lun_month;
      logic [4:0] lun_day;
      logic       month_equals_leap;
      logic       result_valid;
   } rsp_type;

   // walk state carried down the pipeline
   typedef struct packed {
      logic        ok;
      logic        fwd;
      logic [23:0] word;
      logic [8:0]  rem;
      logic [3:0]  month;
      logic [3:0]  slot;
      logic        flag;
   } walk_type;

   function automatic logic [8:0] days_before(input logic [3:0] m);
      case (m)
         4'd1:    days_before = 9'd0;
         4'd2:    days_before = 9'd31;
         4'd3:    days_before = 9'd59;
         4'd4:    days_before = 9'd90;
         4'd5:    days_before = 9'd120;
         4'd6:    days_before = 9'd151;
         4'd7:    days_before = 9'd181;
         4'd8:    days_before = 9'd212;
         4'd9:    days_before = 9'd243;
         4'd10:   days_before = 9'd273;
         4'd11:   days_before = 9'd304;
         4'd12:   days_before = 9'd334;
         default: days_before = 9'd0;
      endcase
   endfunction

   function automatic logic [4:0] slot_len(input logic [23:0] w, input logic [3:0] slot);
      logic [4:0] bi;
      bi = 5'd20 - {1'b0, slot};
      if (slot < 4'd1 || slot > 4'd13) slot_len = 5'd29;
      else slot_len = w[bi] ? 5'd30 : 5'd29;
   endfunction

   function automatic walk_type walk_step(input walk_type s);
      walk_type   r;
      logic [4:0] len;
      r   = s;
      len = slot_len(s.word, s.slot);
      if (s.ok && s.fwd) begin
         if (s.rem >= {4'd0, len}) begin
            r.rem  = s.rem - {4'd0, len};
            r.slot = s.slot + 4'd1;
            if (s.month == s.word[23:20]) begin
               r.flag = !s.flag;
               if (s.flag) r.month = s.month + 4'd1;
            end else begin
               r.month = s.month + 4'd1;
            end
         end
      end else if (s.ok) begin
         if (s.rem > {4'd0, len}) begin
            r.rem  = s.rem - {4'd0, len};
            r.slot = s.slot - 4'd1;
            if (!s.flag) r.month = s.month - 4'd1;
            if (r.month == s.word[23:20]) r.flag = !s.flag;
         end
      end
      walk_step = r;
   endfunction

   function automatic logic [23:0] lunar_rom(input logic [IDX_W-1:0] k);
      case (k)
         8'd0: lunar_rom = 24'h04AE53;   8'd1: lunar_rom = 24'h0A5748;
         8'd2: lunar_rom = 24'h5526BD;   8'd3: lunar_rom = 24'h0D2650;
         8'd4: lunar_rom = 24'h0D9544;   8'd5: lunar_rom = 24'h46AAB9;
         8'd6: lunar_rom = 24'h056A4D;   8'd7: lunar_rom = 24'h09AD42;
         8'd8: lunar_rom = 24'h24AEB6;   8'd9: lunar_rom = 24'h04AE4A;
         8'd10: lunar_rom = 24'h6A4DBE;  8'd11: lunar_rom = 24'h0A4D52;
         8'd12: lunar_rom = 24'h0D2546;  8'd13: lunar_rom = 24'h5D52BA;
         8'd14: lunar_rom = 24'h0B544E;  8'd15: lunar_rom = 24'h0D6A43;
         8'd16: lunar_rom = 24'h296D37;  8'd17: lunar_rom = 24'h095B4B;
         8'd18: lunar_rom = 24'h749BC1;  8'd19: lunar_rom = 24'h049754;
         8'd20: lunar_rom = 24'h0A4B48;  8'd21: lunar_rom = 24'h5B25BC;
         8'd22: lunar_rom = 24'h06A550;  8'd23: lunar_rom = 24'h06D445;
         8'd24: lunar_rom = 24'h4ADAB8;  8'd25: lunar_rom = 24'h02B64D;
         8'd26: lunar_rom = 24'h095742;  8'd27: lunar_rom = 24'h2497B7;
         8'd28: lunar_rom = 24'h04974A;  8'd29: lunar_rom = 24'h664B3E;
         8'd30: lunar_rom = 24'h0D4A51;  8'd31: lunar_rom = 24'h0EA546;
         8'd32: lunar_rom = 24'h56D4BA;  8'd33: lunar_rom = 24'h05AD4E;
         8'd34: lunar_rom = 24'h02B644;  8'd35: lunar_rom = 24'h393738;
         8'd36: lunar_rom = 24'h092E4B;  8'd37: lunar_rom = 24'h7C96BF;
         8'd38: lunar_rom = 24'h0C9553;  8'd39: lunar_rom = 24'h0D4A48;
         8'd40: lunar_rom = 24'h6DA53B;  8'd41: lunar_rom = 24'h0B554F;
         8'd42: lunar_rom = 24'h056A45;  8'd43: lunar_rom = 24'h4AADB9;
         8'd44: lunar_rom = 24'h025D4D;  8'd45: lunar_rom = 24'h092D42;
         8'd46: lunar_rom = 24'h2C95B6;  8'd47: lunar_rom = 24'h0A954A;
         8'd48: lunar_rom = 24'h7B4ABD;  8'd49: lunar_rom = 24'h06CA51;
         8'd50: lunar_rom = 24'h0B5546;  8'd51: lunar_rom = 24'h555ABB;
         8'd52: lunar_rom = 24'h04DA4E;  8'd53: lunar_rom = 24'h0A5B43;
         8'd54: lunar_rom = 24'h352BB8;  8'd55: lunar_rom = 24'h052B4C;
         8'd56: lunar_rom = 24'h8A953F;  8'd57: lunar_rom = 24'h0E9552;
         8'd58: lunar_rom = 24'h06AA48;  8'd59: lunar_rom = 24'h6AD53C;
         8'd60: lunar_rom = 24'h0AB54F;  8'd61: lunar_rom = 24'h04B645;
         8'd62: lunar_rom = 24'h4A5739;  8'd63: lunar_rom = 24'h0A574D;
         8'd64: lunar_rom = 24'h052642;  8'd65: lunar_rom = 24'h3E9335;
         8'd66: lunar_rom = 24'h0D9549;  8'd67: lunar_rom = 24'h75AABE;
         8'd68: lunar_rom = 24'h056A51;  8'd69: lunar_rom = 24'h096D46;
         8'd70: lunar_rom = 24'h54AEBB;  8'd71: lunar_rom = 24'h04AD4F;
         8'd72: lunar_rom = 24'h0A4D43;  8'd73: lunar_rom = 24'h4D26B7;
         8'd74: lunar_rom = 24'h0D254B;  8'd75: lunar_rom = 24'h8D52BF;
         8'd76: lunar_rom = 24'h0B5452;  8'd77: lunar_rom = 24'h0B6A47;
         8'd78: lunar_rom = 24'h696D3C;  8'd79: lunar_rom = 24'h095B50;
         8'd80: lunar_rom = 24'h049B45;  8'd81: lunar_rom = 24'h4A4BB9;
         8'd82: lunar_rom = 24'h0A4B4D;  8'd83: lunar_rom = 24'hAB25C2;
         8'd84: lunar_rom = 24'h06A554;  8'd85: lunar_rom = 24'h06D449;
         8'd86: lunar_rom = 24'h6ADA3D;  8'd87: lunar_rom = 24'h0AB651;
         8'd88: lunar_rom = 24'h093746;  8'd89: lunar_rom = 24'h5497BB;
         8'd90: lunar_rom = 24'h04974F;  8'd91: lunar_rom = 24'h064B44;
         8'd92: lunar_rom = 24'h36A537;  8'd93: lunar_rom = 24'h0EA54A;
         8'd94: lunar_rom = 24'h86B2BF;  8'd95: lunar_rom = 24'h05AC53;
         8'd96: lunar_rom = 24'h0AB647;  8'd97: lunar_rom = 24'h5936BC;
         8'd98: lunar_rom = 24'h092E50;  8'd99: lunar_rom = 24'h0C9645;
         8'd100: lunar_rom = 24'h4D4AB8; 8'd101: lunar_rom = 24'h0D4A4C;
         8'd102: lunar_rom = 24'h0DA541; 8'd103: lunar_rom = 24'h25AAB6;
         8'd104: lunar_rom = 24'h056A49; 8'd105: lunar_rom = 24'h7AADBD;
         8'd106: lunar_rom = 24'h025D52; 8'd107: lunar_rom = 24'h092D47;
         8'd108: lunar_rom = 24'h5C95BA; 8'd109: lunar_rom = 24'h0A954E;
         8'd110: lunar_rom = 24'h0B4A43; 8'd111: lunar_rom = 24'h4B5537;
         8'd112: lunar_rom = 24'h0AD54A; 8'd113: lunar_rom = 24'h955ABF;
         8'd114: lunar_rom = 24'h04BA53; 8'd115: lunar_rom = 24'h0A5B48;
         8'd116: lunar_rom = 24'h652BBC; 8'd117: lunar_rom = 24'h052B50;
         8'd118: lunar_rom = 24'h0A9345; 8'd119: lunar_rom = 24'h474AB9;
         8'd120: lunar_rom = 24'h06AA4C; 8'd121: lunar_rom = 24'h0AD541;
         8'd122: lunar_rom = 24'h24DAB6; 8'd123: lunar_rom = 24'h04B64A;
         8'd124: lunar_rom = 24'h69573D; 8'd125: lunar_rom = 24'h0A4E51;
         8'd126: lunar_rom = 24'h0D2646; 8'd127: lunar_rom = 24'h5E933A;
         8'd128: lunar_rom = 24'h0D534D; 8'd129: lunar_rom = 24'h05AA43;
         8'd130: lunar_rom = 24'h36B537; 8'd131: lunar_rom = 24'h096D4B;
         8'd132: lunar_rom = 24'hB4AEBF; 8'd133: lunar_rom = 24'h04AD53;
         8'd134: lunar_rom = 24'h0A4D48; 8'd135: lunar_rom = 24'h6D25BC;
         8'd136: lunar_rom = 24'h0D254F; 8'd137: lunar_rom = 24'h0D5244;
         8'd138: lunar_rom = 24'h5DAA38; 8'd139: lunar_rom = 24'h0B5A4C;
         8'd140: lunar_rom = 24'h056D41; 8'd141: lunar_rom = 24'h24ADB6;
         8'd142: lunar_rom = 24'h049B4A; 8'd143: lunar_rom = 24'h7A4BBE;
         8'd144: lunar_rom = 24'h0A4B51; 8'd145: lunar_rom = 24'h0AA546;
         8'd146: lunar_rom = 24'h5B52BA; 8'd147: lunar_rom = 24'h06D24E;
         8'd148: lunar_rom = 24'h0ADA42; 8'd149: lunar_rom = 24'h355B37;
         8'd150: lunar_rom = 24'h09374B; 8'd151: lunar_rom = 24'h8497C1;
         8'd152: lunar_rom = 24'h049753; 8'd153: lunar_rom = 24'h064B48;
         8'd154: lunar_rom = 24'h66A53C; 8'd155: lunar_rom = 24'h0EA54F;
         8'd156: lunar_rom = 24'h06B244; 8'd157: lunar_rom = 24'h4AB638;
         8'd158: lunar_rom = 24'h0AAE4C; 8'd159: lunar_rom = 24'h092E42;
         8'd160: lunar_rom = 24'h3C9735; 8'd161: lunar_rom = 24'h0C9649;
         8'd162: lunar_rom = 24'h7D4ABD; 8'd163: lunar_rom = 24'h0D4A51;
         8'd164: lunar_rom = 24'h0DA545; 8'd165: lunar_rom = 24'h55AABA;
         8'd166: lunar_rom = 24'h056A4E; 8'd167: lunar_rom = 24'h0A6D43;
         8'd168: lunar_rom = 24'h452EB7; 8'd169: lunar_rom = 24'h052D4B;
         8'd170: lunar_rom = 24'h8A95BF; 8'd171: lunar_rom = 24'h0A9553;
         8'd172: lunar_rom = 24'h0B4A47; 8'd173: lunar_rom = 24'h6B553B;
         8'd174: lunar_rom = 24'h0AD54F; 8'd175: lunar_rom = 24'h055A45;
         8'd176: lunar_rom = 24'h4A5D38; 8'd177: lunar_rom = 24'h0A5B4C;
         8'd178: lunar_rom = 24'h052B42; 8'd179: lunar_rom = 24'h3A93B6;
         8'd180: lunar_rom = 24'h069349; 8'd181: lunar_rom = 24'h7729BD;
         8'd182: lunar_rom = 24'h06AA51; 8'd183: lunar_rom = 24'h0AD546;
         8'd184: lunar_rom = 24'h54DABA; 8'd185: lunar_rom = 24'h04B64E;
         8'd186: lunar_rom = 24'h0A5743; 8'd187: lunar_rom = 24'h452738;
         8'd188: lunar_rom = 24'h0D264A; 8'd189: lunar_rom = 24'h8E933E;
         8'd190: lunar_rom = 24'h0D5252; 8'd191: lunar_rom = 24'h0DAA47;
         8'd192: lunar_rom = 24'h66B53B; 8'd193: lunar_rom = 24'h056D4F;
         8'd194: lunar_rom = 24'h04AE45; 8'd195: lunar_rom = 24'h4A4EB9;
         8'd196: lunar_rom = 24'h0A4D4C; 8'd197: lunar_rom = 24'h0D1541;
         8'd198: lunar_rom = 24'h2D92B5;
         default: lunar_rom = 24'h000000;
      endcase
   endfunction

endpackage

[rtl/gcld_walk_stage.sv]
// ----------------------------------------------------------------------------
// gcld_walk_stage
// One pipeline stage of the month walk: two month steps, then a register.
// ----------------------------------------------------------------------------
module gcld_walk_stage import gcld_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  walk_type in_walk,
   output logic     out_valid,
   output walk_type out_walk
);

   logic     valid_ff, valid_in;
   walk_type walk_ff, walk_in;

   assign valid_in = in_valid;
   assign walk_in  = walk_step(walk_step(in_walk));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         walk_ff <= walk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_walk  = walk_ff;

endmodule

[rtl/gregorian_to_chinese_lunar_date_core.sv]
// ----------------------------------------------------------------------------
// gregorian_to_chinese_lunar_date_core
// Gregorian date to Chinese lunar month and day, years 1901 to 2099.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one Gregorian date per item.
//   rsp_valid/rsp_stall/rsp_data carry one lunar result per item.
//   An item transfers on a clock edge with valid high and stall low.
// Pipeline: ten register stages (decode, table lookup, seven walk stages
//   of two month steps each, output stage).
// Throughput: one item per cycle unless the output stalls; the pipeline is fully registered.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline
//   holds and req_stall is raised; nothing is dropped or repeated.
// Reset: synchronous, clears all valid bits; the pipeline is empty after.
// Dates without a table entry, bad months and day zero give result_valid
//   low with all other result fields zero.
// ----------------------------------------------------------------------------
module gregorian_to_chinese_lunar_date_core import gcld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic en;

   // decode stage
   logic             s1_valid_ff, s1_ok_ff, s1_prev_ok_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [8:0]       s1_sun_ff;
   logic             s1_ok_in, s1_prev_ok_in;
   logic [IDX_W-1:0] s1_idx_in;
   logic [8:0]       s1_sun_in;
   logic [11:0]      year_off;

   // lookup stage
   logic     s2_valid_ff;
   walk_type s2_walk_ff, s2_walk_in;
   logic [23:0] w_cur, w_prev;
   logic [5:0]  spring;

   // walk chain
   logic     wv   [WALK_STAGES+1];
   walk_type ws   [WALK_STAGES+1];

   // output stage
   logic    out_valid_ff;
   rsp_type out_ff, out_in;
   walk_type fin;
   logic [4:0] fin_len;

   assign en        = !(out_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign year_off      = req_data.greg_year - YEAR_LO;
   assign s1_ok_in      = (req_data.greg_month >= 4'd1) && (req_data.greg_month <= 4'd12)
                          && (req_data.greg_day != 5'd0)
                          && (req_data.greg_year >= YEAR_LO) && (req_data.greg_year <= YEAR_HI);
   assign s1_idx_in     = year_off[IDX_W-1:0];
   assign s1_prev_ok_in = (year_off != 12'd0);
   assign s1_sun_in     = days_before(req_data.greg_month) + {4'd0, req_data.greg_day} - 9'd1
                          + {8'd0, (req_data.greg_year[1:0] == 2'd0)
                                   && (req_data.greg_month > 4'd2)};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ok_ff      <= s1_ok_in;
         s1_prev_ok_ff <= s1_prev_ok_in;
         s1_idx_ff     <= s1_idx_in;
         s1_sun_ff     <= s1_sun_in;
      end
   end

   assign w_cur  = lunar_rom(s1_idx_ff);
   assign w_prev = lunar_rom(s1_idx_ff - 8'd1);
   assign spring = {1'b0, w_cur[4:0]} - 6'd1 + ((w_cur[6:5] != 2'd1) ? 6'd31 : 6'd0);

   always_comb begin
      s2_walk_in      = '0;
      s2_walk_in.flag = 1'b0;
      if (s1_sun_ff >= {3'd0, spring}) begin
         s2_walk_in.ok    = s1_ok_ff;
         s2_walk_in.fwd   = 1'b1;
         s2_walk_in.word  = w_cur;
         s2_walk_in.rem   = s1_sun_ff - {3'd0, spring};
         s2_walk_in.month = 4'd1;
         s2_walk_in.slot  = 4'd1;
      end else begin
         s2_walk_in.ok    = s1_ok_ff && s1_prev_ok_ff;
         s2_walk_in.fwd   = 1'b0;
         s2_walk_in.word  = w_prev;
         s2_walk_in.rem   = {3'd0, spring} - s1_sun_ff;
         s2_walk_in.month = 4'd12;
         s2_walk_in.slot  = (w_prev[23:20] == 4'd0) ? 4'd12 : 4'd13;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_walk_ff <= s2_walk_in;
      end
   end

   assign wv[0] = s2_valid_ff;
   assign ws[0] = s2_walk_ff;

   for (genvar g = 0; g < WALK_STAGES; g++) begin : g_walk
      gcld_walk_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (wv[g]),
         .in_walk   (ws[g]),
         .out_valid (wv[g+1]),
         .out_walk  (ws[g+1])
      );
   end

   assign fin     = ws[WALK_STAGES];
   assign fin_len = slot_len(fin.word, fin.slot);

   always_comb begin
      out_in = '0;
      if (fin.ok) begin
         out_in.lun_month         = fin.month;
         out_in.lun_day           = fin.fwd ? 5'(fin.rem + 9'd1)
                                            : 5'({4'd0, fin_len} - fin.rem + 9'd1);
         out_in.month_equals_leap = (fin.month == fin.word[23:20]);
         out_in.result_valid      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= wv[WALK_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output stall");
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_valid) |->
         (rsp_data.lun_month >= 4'd1 && rsp_data.lun_month <= 4'd12))
      else $error("lunar month out of range");
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_valid) |->
         (rsp_data.lun_day >= 5'd1 && rsp_data.lun_day <= 5'd30))
      else $error("lunar day out of range");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.result_valid) |->
         (rsp_data.lun_month == 4'd0 && rsp_data.lun_day == 5'd0
          && !rsp_data.month_equals_leap))
      else $error("invalid item carries non-zero fields");
`endif

endmodule

[test/tb_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checker
// Watches both channels, predicts each lunar date and compares each whole result.
// ----------------------------------------------------------------------------
module tb_checker import gcld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   localparam logic [23:0] YEAR_WORDS [0:198] = '{
      24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
      24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
      24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
      24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
      24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
      24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
      24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
      24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
      24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
      24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
      24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
      24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
      24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
      24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
      24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
      24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
      24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
      24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
      24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
      24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
      24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
      24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
      24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
      24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
      24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
      24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
      24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
      24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
      24'h0A4D4C,24'h0D1541,24'h2D92B5};

   rsp_type lunar_q[$];

   function automatic int month_days(input logic [23:0] w, input int m);
      if (m < 1 || m > 13) return 29;
      return w[20 - m] ? 30 : 29;
   endfunction

   function automatic rsp_type lunar_of(input req_type d);
      rsp_type r;
      logic [23:0] w;
      int yr, spring, doy, len, m, mon, leap;
      bit second;
      int cum [12];
      r = '0;
      cum = '{0,31,59,90,120,151,181,212,243,273,304,334};
      yr = d.greg_year;
      second = 0;
      if (d.greg_month < 1 || d.greg_month > 12 || d.greg_day == 0) return r;
      if (yr < FIRST_YEAR || yr >= FIRST_YEAR + YEAR_COUNT) return r;
      w = YEAR_WORDS[yr - FIRST_YEAR];
      spring = int'(w[4:0]) - 1;
      if (w[6:5] != 2'd1) spring += 31;
      doy = cum[d.greg_month - 1] + d.greg_day - 1;
      if (yr % 4 == 0 && d.greg_month > 2) doy++;
      if (doy >= spring) begin
         leap = w[23:20];
         doy -= spring;
         mon = 1;
         m = 1;
         len = month_days(w, m);
         while (doy >= len) begin
            doy -= len;
            m++;
            if (mon == leap) begin
               second = !second;
               if (!second) mon++;
            end else mon++;
            len = month_days(w, m);
         end
         r.lun_day = 5'(doy + 1);
      end else begin
         if (yr - 1 < FIRST_YEAR) return r;
         w = YEAR_WORDS[yr - 1 - FIRST_YEAR];
         leap = w[23:20];
         spring -= doy;
         mon = 12;
         m = (leap == 0) ? 12 : 13;
         len = month_days(w, m);
         while (spring > len) begin
            spring -= len;
            m--;
            if (!second) mon--;
            if (mon == leap) second = !second;
            len = month_days(w, m);
         end
         r.lun_day = 5'(len - spring + 1);
      end
      r.lun_month = 4'(mon);
      r.month_equals_leap = (mon == leap);
      r.result_valid = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         lunar_q.delete();
         pending <= 0;
      end else begin
         if (req_valid && !req_stall) lunar_q.push_back(lunar_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (lunar_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected item %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = lunar_q.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) $display("mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= lunar_q.size();
      end
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random Gregorian dates, with idle request gaps and random response stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import gcld_pkg::*;

   logic    clock = 0, reset = 1;
   logic    req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   int      fail_count, pending, cycles = 0;
   bit      done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   gregorian_to_chinese_lunar_date_core dut (.*);
   tb_checker u_checker (.*);

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send(input req_type d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_type rand_date();
      req_type d;
      int p;
      p = $urandom_range(0, 99);
      d.greg_year  = 12'($urandom_range(1901, 2099));
      d.greg_month = 4'($urandom_range(1, 12));
      d.greg_day   = 5'($urandom_range(1, 31));
      if (p < 20) d.greg_month = 4'($urandom_range(1, 3));
      else if (p < 26) d.greg_year = 12'($urandom_range(1901, 1902));
      else if (p < 30) d.greg_year = 12'($urandom);
      else if (p < 33) d.greg_month = 4'($urandom);
      else if (p < 36) d.greg_day = 5'($urandom);
      return d;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 11) reset <= 0;
      if (cycles > 200000) begin
         $display("FAIL gregorian_to_chinese_lunar_date_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (done) rsp_stall <= 0;
      else if ($urandom_range(0, 99) < 70) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 9) < 8) ? 1'b1 : ($urandom_range(0, 1) == 1);
   end

   initial begin
      req_type d;
      req_type dir [$];
      dir = '{
         '{12'd1901, 4'd1, 5'd1}, '{12'd1901, 4'd2, 5'd18}, '{12'd1901, 4'd2, 5'd19},
         '{12'd1901, 4'd2, 5'd20}, '{12'd1902, 4'd1, 5'd1}, '{12'd2099, 4'd12, 5'd31},
         '{12'd2099, 4'd1, 5'd1}, '{12'd1900, 4'd6, 5'd1}, '{12'd2100, 4'd6, 5'd1},
         '{12'hFFF, 4'd6, 5'd1}, '{12'd0, 4'd1, 5'd1}, '{12'd2000, 4'd0, 5'd1},
         '{12'd2000, 4'd13, 5'd1}, '{12'd2000, 4'hF, 5'd1}, '{12'd2000, 4'd5, 5'd0},
         '{12'd2000, 4'd3, 5'd1}, '{12'd2001, 4'd3, 5'd1}, '{12'd1906, 4'd6, 5'd15},
         '{12'd1987, 4'd7, 5'd30}, '{12'd2023, 4'd4, 5'd20}, '{12'd2023, 4'd12, 5'd31},
         '{12'd2033, 4'd12, 5'd25}, '{12'd1955, 4'd1, 5'd31}, '{12'd2020, 4'd5, 5'd31}};
      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (dir[i]) send(dir[i]);
      for (int n = 0; n < 1200; n++) begin
         if (n == 600) begin
            req_valid <= 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         d = rand_date();
         send(d);
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      done = 1;
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("PASS gregorian_to_chinese_lunar_date_core");
      else $display("FAIL gregorian_to_chinese_lunar_date_core");
      $finish;
   end

endmodule

[filelist.f]
rtl/gcld_pkg.sv
rtl/gcld_walk_stage.sv
rtl/gregorian_to_chinese_lunar_date_core.sv
test/tb_checker.sv
test/tb_top.sv
